>>> hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the pixel tint blend checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, masked while reset is active.
`define PTB_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) prop) else $error(msg);

// Clocked assertion that also holds across reset.
`define PTB_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> hw/rtl/ptb_pkg.sv
// ----------------------------------------------------------------------------
// ptb_pkg
// Types, constants and per-channel arithmetic for the pixel tint blend.
// ----------------------------------------------------------------------------
package ptb_pkg;

    localparam int unsigned PixW   = 32;
    localparam int unsigned ChanW  = 8;
    localparam int unsigned CfgIdxW = 3;

    typedef logic [PixW-1:0]    t_pixel;
    typedef logic [ChanW-1:0]   t_chan;
    typedef logic [CfgIdxW-1:0] t_cfg_idx;

    typedef enum logic [1:0] {
        FMT_RGB565     = 2'd0,
        FMT_ARGB32     = 2'd1,
        FMT_ARGB_TO565 = 2'd2
    } t_fmt_mode;

    localparam t_cfg_idx REG_TINT_RED   = 3'd0;
    localparam t_cfg_idx REG_TINT_GREEN = 3'd1;
    localparam t_cfg_idx REG_TINT_BLUE  = 3'd2;
    localparam t_cfg_idx REG_TINT_LEVEL = 3'd3;
    localparam t_cfg_idx REG_FMT_MODE   = 3'd4;

    localparam t_chan TINT_RESET  = 8'd238;
    localparam t_chan LEVEL_RESET = 8'd64;
    localparam t_chan CHAN_MAX    = 8'hff;

    localparam logic [3:0] SH_RED565   = 4'd11;
    localparam logic [3:0] SH_GREEN565 = 4'd5;
    localparam logic [3:0] SH_NONE     = 4'd0;

    // floor(x / 255) for x < 255 * 2^16: shift-add estimate, then one correction
    function automatic logic [15:0] div255(input logic [23:0] x);
        logic [24:0] acc;
        logic [16:0] q;
        logic [24:0] rem;
        acc = {1'b0, x} + {9'b0, x[23:8]} + {17'b0, x[23:16]};
        q   = acc[24:8];
        rem = {1'b0, x} - ({q, 8'b0} - {8'b0, q});
        if (rem >= 25'd255) begin
            q = q + 17'd1;
        end
        return q[15:0];
    endfunction

    // (s*keep + t*level) << sh, divided by 255
    function automatic logic [15:0] blend_ch(input t_chan s, input t_chan t,
                                             input t_chan keep, input t_chan level,
                                             input logic [3:0] sh);
        logic [15:0] sum;
        logic [23:0] x;
        sum = {8'b0, s} * {8'b0, keep} + {8'b0, t} * {8'b0, level};
        x   = 24'({8'b0, sum} << sh);
        return div255(x);
    endfunction

endpackage

>>> hw/rtl/pixel_tint_blend.sv
// ----------------------------------------------------------------------------
// pixel_tint_blend
// Blends each pixel of a stream toward a constant tint color.
// ----------------------------------------------------------------------------
// One pixel in, one pixel out, one pixel per cycle sustained while i_m_tready
// stays high. An accepted pixel is held in an input register, and per-channel
// 8x8 multiply-adds and a shift-add divide by 255 sit between it and the
// output register that drives o_m_tvalid. Both registers stall on
// backpressure; while a result waits the input register still takes one
// more pixel, then o_s_tready drops. Configuration is always accepted;
// write it only while the stream is idle.
module pixel_tint_blend (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // configuration write channel
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  ptb_pkg::t_cfg_idx     i_cfg_index,
    input  ptb_pkg::t_chan        i_cfg_data,
    // source pixels
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    input  ptb_pkg::t_pixel       i_s_tdata,   // [31:0] source_pixel
    // tinted pixels
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    output ptb_pkg::t_pixel       o_m_tdata    // [31:0] tinted_pixel
);
    import ptb_pkg::*;

    t_chan     r_tint_red, r_tint_green, r_tint_blue, r_level;
    t_fmt_mode r_mode;

    logic   r_in_valid, r_out_valid;
    t_pixel r_in_pixel, r_out_pixel;
    t_pixel n_out_pixel;

    logic out_ready, in_ready;

    t_chan       keep;
    t_chan       s_r, s_g, s_b, t_r, t_g, t_b;
    logic [3:0]  sh_r, sh_g;
    logic [15:0] q_r, q_g, q_b;
    logic        is565;

    assign o_cfg_ready = 1'b1;

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tint_red   <= TINT_RESET;
            r_tint_green <= TINT_RESET;
            r_tint_blue  <= TINT_RESET;
            r_level      <= LEVEL_RESET;
            r_mode       <= FMT_RGB565;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_TINT_RED:   r_tint_red   <= i_cfg_data;
                REG_TINT_GREEN: r_tint_green <= i_cfg_data;
                REG_TINT_BLUE:  r_tint_blue  <= i_cfg_data;
                REG_TINT_LEVEL: r_level      <= i_cfg_data;
                REG_FMT_MODE:   r_mode       <= t_fmt_mode'(i_cfg_data[1:0]);
                default: ;
            endcase
        end
    end

    assign out_ready  = !r_out_valid || i_m_tready;
    assign in_ready   = !r_in_valid || out_ready;
    assign o_s_tready = in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_ready) begin
                r_in_valid <= i_s_tvalid;
            end
            if (out_ready) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_ready && i_s_tvalid) begin
            r_in_pixel <= i_s_tdata;
        end
        if (out_ready && r_in_valid) begin
            r_out_pixel <= n_out_pixel;
        end
    end

    // channel operand select: 565 fields right-aligned and shifted back by sh, or 8-bit channels
    always_comb begin
        keep  = CHAN_MAX - r_level;
        is565 = (r_mode == FMT_RGB565);
        if (is565) begin
            s_r  = {3'b0, r_in_pixel[15:11]};
            s_g  = {2'b0, r_in_pixel[10:5]};
            s_b  = {3'b0, r_in_pixel[4:0]};
            t_r  = {3'b0, r_tint_red[7:3]};
            t_g  = {2'b0, r_tint_green[7:2]};
            t_b  = {3'b0, r_tint_blue[7:3]};
            sh_r = SH_RED565;
            sh_g = SH_GREEN565;
        end else begin
            s_r  = r_in_pixel[23:16];
            s_g  = r_in_pixel[15:8];
            s_b  = r_in_pixel[7:0];
            t_r  = r_tint_red;
            t_g  = r_tint_green;
            t_b  = r_tint_blue;
            sh_r = SH_NONE;
            sh_g = SH_NONE;
        end
        q_r = blend_ch(s_r, t_r, keep, r_level, sh_r);
        q_g = blend_ch(s_g, t_g, keep, r_level, sh_g);
        q_b = blend_ch(s_b, t_b, keep, r_level, SH_NONE);

        case (r_mode)
            FMT_RGB565:     n_out_pixel = {16'b0, q_r[15:11], q_g[10:5], q_b[4:0]};
            FMT_ARGB32:     n_out_pixel = {CHAN_MAX, q_r[7:0], q_g[7:0], q_b[7:0]};
            FMT_ARGB_TO565: n_out_pixel = {16'b0, q_r[7:3], q_g[7:2], q_b[7:3]};
            default:        n_out_pixel = '0;
        endcase
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_pixel;

endmodule

>>> hw/rtl/ptb_checker.sv
// ----------------------------------------------------------------------------
// ptb_checker
// Port-level checks for pixel_tint_blend, bound into every instance of it.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ptb_checker (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  o_s_tready,
    input logic                  o_m_tvalid,
    input logic                  i_m_tready,
    input ptb_pkg::t_pixel       o_m_tdata
);
    import ptb_pkg::*;

    `PTB_ASSERT(a_out_hold, i_clk, i_rst_n,
        o_m_tvalid && !i_m_tready |=> o_m_tvalid,
        "output request dropped while stalled")
    `PTB_ASSERT(a_out_stable, i_clk, i_rst_n,
        o_m_tvalid && !i_m_tready |=> $stable(o_m_tdata),
        "output data changed while stalled")
    `PTB_ASSERT(a_stall_cause, i_clk, i_rst_n,
        !o_s_tready |-> o_m_tvalid && !i_m_tready,
        "input stalled with free pipeline")
    `PTB_ASSERT(a_pix_form, i_clk, i_rst_n,
        o_m_tvalid |-> (o_m_tdata[31:24] == CHAN_MAX || o_m_tdata[31:16] == 16'h0),
        "output neither opaque argb nor 565")
    `PTB_ASSERT_ALWAYS(a_rst_clear, i_clk,
        !i_rst_n |=> !o_m_tvalid,
        "output valid after reset")

endmodule

bind pixel_tint_blend ptb_checker u_ptb_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);

>>> bench/pixel_tint_blend_tb.sv
// ----------------------------------------------------------------------------
// pixel_tint_blend_tb
// Self-checking bench for the tint blend stream block. Source pixels go in
// through the slave stream and tint settings through the config channel. A
// scoreboard works out every tinted pixel from its own copy of the settings
// and compares the master stream against it in order. Both stream sides idle
// at random, with one stall-free stretch and one long output hold-off.
// ----------------------------------------------------------------------------
module pixel_tint_blend_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ptb_pkg::*;

    localparam int unsigned FULL_SCALE = 255;
    localparam int unsigned MASK_R565  = 32'h0000_F800;
    localparam int unsigned MASK_G565  = 32'h0000_07E0;
    localparam int unsigned MASK_B565  = 32'h0000_001F;
    localparam logic [1:0]  FMT_UNUSED = 2'd3;
    localparam t_cfg_idx    FIRST_SPARE_REG = REG_FMT_MODE + 3'd1;
    localparam int HOLD_CYCLES     = 300;
    localparam int STALL_LIMIT     = 2000;
    localparam int RANDOM_SETTINGS = 25;
    localparam int MAX_REPORTS     = 10;

    class tint_checker;
        t_chan      red, green, blue, level;
        logic [1:0] mode;
        t_pixel     tinted_due[$];
        int         mismatches;
        int         checked;

        function new();
            red        = TINT_RESET;
            green      = TINT_RESET;
            blue       = TINT_RESET;
            level      = LEVEL_RESET;
            mode       = FMT_RGB565;
            mismatches = 0;
            checked    = 0;
        endfunction

        function void write_reg(t_cfg_idx idx, t_chan data);
            case (idx)
                REG_TINT_RED:   red   = data;
                REG_TINT_GREEN: green = data;
                REG_TINT_BLUE:  blue  = data;
                REG_TINT_LEVEL: level = data;
                REG_FMT_MODE:   mode  = data[1:0];
                default: ;
            endcase
        endfunction

        function t_pixel tint_of(t_pixel px);
            int unsigned lv, keep, r, g, b, tr, tg, tb;
            t_pixel res;
            lv   = level;
            keep = FULL_SCALE - lv;
            res  = '0;
            case (mode)
                FMT_RGB565: begin
                    // tint pre-shifted into the 565 field positions
                    tr  = (32'(red) << 8) & MASK_R565;
                    tg  = (32'(green) << 3) & MASK_G565;
                    tb  = 32'(blue) >> 3;
                    r   = ((px & MASK_R565) * keep + tr * lv) / FULL_SCALE;
                    g   = ((px & MASK_G565) * keep + tg * lv) / FULL_SCALE;
                    b   = ((px & MASK_B565) * keep + tb * lv) / FULL_SCALE;
                    res = (r & MASK_R565) | (g & MASK_G565) | (b & MASK_B565);
                end
                FMT_ARGB32, FMT_ARGB_TO565: begin
                    r = (32'(red) * lv + 32'(px[23:16]) * keep) / FULL_SCALE;
                    g = (32'(green) * lv + 32'(px[15:8]) * keep) / FULL_SCALE;
                    b = (32'(blue) * lv + 32'(px[7:0]) * keep) / FULL_SCALE;
                    if (mode == FMT_ARGB32) begin
                        res = {CHAN_MAX, r[7:0], g[7:0], b[7:0]};
                    end else begin
                        res = (((r >> 3) << 11) & MASK_R565) | (((g >> 2) << 5) & MASK_G565)
                            | ((b >> 3) & MASK_B565);
                    end
                end
                default: res = '0;
            endcase
            return res;
        endfunction

        function void note_source(t_pixel px);
            tinted_due.push_back(tint_of(px));
        endfunction

        function void check_tinted(t_pixel got);
            t_pixel want;
            if (tinted_due.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS) begin
                    $display("unexpected tinted pixel %08h", got);
                end
                return;
            end
            want = tinted_due.pop_front();
            checked++;
            if (got !== want) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS) begin
                    $display("tinted pixel mismatch: expected %08h, got %08h", want, got);
                end
            end
        endfunction

        function int pending();
            return tinted_due.size();
        endfunction
    endclass

    logic     i_clk = 1'b0;
    logic     i_rst_n;
    logic     i_cfg_valid;
    logic     o_cfg_ready;
    t_cfg_idx i_cfg_index;
    t_chan    i_cfg_data;
    logic     i_s_tvalid;
    logic     o_s_tready;
    t_pixel   i_s_tdata;
    logic     o_m_tvalid;
    logic     i_m_tready;
    t_pixel   o_m_tdata;

    tint_checker tracker;
    bit gaps_on      = 1'b1;
    bit stalls_on    = 1'b1;
    bit hold_pending = 1'b0;
    int settings     = 0;
    int quiet_cycles = 0;

    always #5ns i_clk = ~i_clk;

    pixel_tint_blend DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata)
    );

    // monitor and watchdog
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) begin
                tracker.write_reg(i_cfg_index, i_cfg_data);
            end
            if (i_s_tvalid && o_s_tready) begin
                tracker.note_source(i_s_tdata);
            end
            if (o_m_tvalid && i_m_tready) begin
                tracker.check_tinted(o_m_tdata);
            end
            if ((i_cfg_valid && o_cfg_ready) || (i_s_tvalid && o_s_tready)
                || (o_m_tvalid && i_m_tready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("timeout: no request accepted for %0d cycles", STALL_LIMIT);
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    // result sink
    initial begin : sink
        forever begin
            @(posedge i_clk);
            if (hold_pending) begin
                hold_pending = 1'b0;
                i_m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else begin
                i_m_tready <= !(stalls_on && $urandom_range(99) < 8);
            end
        end
    end

    task automatic write_reg(input t_cfg_idx idx, input t_chan data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    // spare writes land on unused indexes after the real ones
    task automatic set_tint(input t_chan r, input t_chan g, input t_chan b,
                            input t_chan lv, input logic [1:0] fmt, input int spares);
        write_reg(REG_TINT_RED, r);
        write_reg(REG_TINT_GREEN, g);
        write_reg(REG_TINT_BLUE, b);
        write_reg(REG_TINT_LEVEL, lv);
        write_reg(REG_FMT_MODE, {6'($urandom), fmt});
        for (int k = 0; k < spares; k++) begin
            write_reg(t_cfg_idx'(FIRST_SPARE_REG + k), t_chan'($urandom));
        end
        i_cfg_valid <= 1'b0;
        settings++;
    endtask

    task automatic send_pixel(input t_pixel px);
        while (gaps_on && $urandom_range(99) < 8) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= px;
        do @(posedge i_clk); while (!o_s_tready);
    endtask

    task automatic settle();
        i_s_tvalid <= 1'b0;
        do @(posedge i_clk); while (tracker.pending() != 0);
    endtask

    function automatic t_chan rand_chan();
        case ($urandom_range(5))
            0:       return '0;
            1:       return CHAN_MAX;
            default: return t_chan'($urandom);
        endcase
    endfunction

    function automatic logic [1:0] rand_fmt();
        int m;
        m = $urandom_range(9);
        if (m < 3) begin
            return FMT_RGB565;
        end else if (m < 6) begin
            return FMT_ARGB32;
        end else if (m < 9) begin
            return FMT_ARGB_TO565;
        end
        return FMT_UNUSED;
    endfunction

    function automatic t_pixel rand_pixel();
        t_pixel px;
        px = $urandom;
        for (int k = 0; k < 4; k++) begin
            case ($urandom_range(15))
                0: px[8*k +: 8] = '0;
                1: px[8*k +: 8] = CHAN_MAX;
                default: ;
            endcase
        end
        return px;
    endfunction

    initial begin
        int n_items;
        tracker     = new();
        i_rst_n     = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = REG_TINT_RED;
        i_cfg_data  = '0;
        i_s_tvalid  = 1'b0;
        i_s_tdata   = '0;
        i_m_tready  = 1'b1;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings, rgb565; upper source bits must not matter
        send_pixel(32'h0000_0000);
        send_pixel(32'hFFFF_FFFF);
        send_pixel(32'hFFFF_0000);
        send_pixel(32'h0000_F800);
        send_pixel(32'h0000_07E0);
        send_pixel(32'h0000_001F);
        settle();

        // no tint weight: source passes, alpha forced
        set_tint(CHAN_MAX, CHAN_MAX, CHAN_MAX, '0, FMT_ARGB32, 0);
        send_pixel(32'h0000_0000);
        send_pixel(32'hFFFF_FFFF);
        send_pixel(32'h00FF_0000);
        send_pixel(32'h0000_FF00);
        send_pixel(32'h0000_00FF);
        send_pixel(32'hFF00_0000);
        settle();

        set_tint(CHAN_MAX, '0, CHAN_MAX, 8'd128, FMT_ARGB_TO565, 0);
        send_pixel(32'h0000_0000);
        send_pixel(32'hFFFF_FFFF);
        send_pixel(32'h00FF_00FF);
        send_pixel(32'h0000_FF00);
        send_pixel(32'h8080_8080);
        settle();

        set_tint(CHAN_MAX, CHAN_MAX, CHAN_MAX, CHAN_MAX, FMT_RGB565, 0);
        send_pixel(32'h0000_0000);
        send_pixel(32'hFFFF_FFFF);
        settle();

        // unused format, then writes to every unused index
        set_tint(8'd12, 8'd200, 8'd77, 8'd99, FMT_UNUSED, 3);
        send_pixel(32'hFFFF_FFFF);
        send_pixel(32'h1234_5678);
        settle();

        set_tint(8'd1, 8'd254, 8'd128, 8'd127, FMT_ARGB32, 3);
        send_pixel(32'h80FF_7F01);
        send_pixel(32'h7F00_80FE);
        settle();

        for (int s = 0; s < RANDOM_SETTINGS; s++) begin
            gaps_on   = !(s >= 4 && s <= 6);
            stalls_on = gaps_on;
            set_tint(rand_chan(), rand_chan(), rand_chan(), rand_chan(), rand_fmt(),
                     $urandom_range(3));
            if (s == 8) begin
                hold_pending = 1'b1;
            end
            n_items = $urandom_range(82, 40);
            for (int i = 0; i < n_items; i++) begin
                send_pixel(rand_pixel());
            end
            settle();
        end

        repeat (8) @(posedge i_clk);
        if (tracker.pending() != 0) begin
            $display("%0d tinted pixels never came out", tracker.pending());
            tracker.mismatches += tracker.pending();
        end
        $display("checked %0d tinted pixels over %0d tint settings in every format",
                 tracker.checked, settings);
        $display("incl. unused format, unused indexes, stall-free run and output hold-off");
        if (tracker.mismatches == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
